// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the RTL of the hyperspherical mapping block.
// No dependencies; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(lbl, clk, rstn, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (b)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rstn, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (b)) \
        else $error("assertion failed");

`endif

// ===== hw/rtl/hstc_pkg.sv =====
// Package for the hyperspherical to Cartesian mapping block.
// Holds widths, fixed-point constants, the arctangent table and a rounding helper.
`default_nettype none
package hstc_pkg;

    localparam int DIM_DEF   = 3;
    localparam int STEPS_DEF = 24;
    localparam int CW        = 34;

    localparam logic signed [CW-1:0] Q28_PI      = 34'sd843314857;
    localparam logic signed [CW-1:0] Q28_HALF_PI = 34'sd421657428;
    localparam logic signed [CW-1:0] Q28_TWO_PI  = 34'sd1686629713;
    localparam logic signed [CW-1:0] Q30_GAIN    = 34'sd652032874;

    localparam logic [1:0] ORD_VAL  = 2'd0;
    localparam logic [1:0] ORD_JAC  = 2'd1;
    localparam logic [1:0] ORD_HESS = 2'd2;

    typedef logic signed [CW-1:0] cw_t;
    typedef logic signed [31:0]   q_t;

    // Per-entry bookkeeping carried alongside the arithmetic.
    typedef struct packed {
        logic [1:0] ci;
        logic [1:0] fj;
        logic [1:0] sk;
        logic       last;
        logic [1:0] d0;
    } meta_t;

    function automatic cw_t atan_q28(input int idx);
        logic [31:0] v;
        case (idx)
            0:  v = 32'd210828714;
            1:  v = 32'd124459457;
            2:  v = 32'd65760959;
            3:  v = 32'd33381290;
            4:  v = 32'd16755422;
            5:  v = 32'd8385879;
            6:  v = 32'd4193963;
            7:  v = 32'd2097109;
            8:  v = 32'd1048571;
            9:  v = 32'd524287;
            28: v = 32'd1;
            29: v = 32'd1;
            default: v = 32'd1 << (28 - idx);
        endcase
        return cw_t'(v);
    endfunction

    // Round half away from zero over sh bits.
    function automatic logic signed [63:0] rnd(input logic signed [63:0] v, input int sh);
        logic [63:0] mag;
        mag = v[63] ? 64'(-v) : 64'(v);
        mag = (mag + (64'd1 << (sh - 1))) >> sh;
        return v[63] ? -$signed(mag) : $signed(mag);
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/hstc_cordic.sv =====
// Pipelined CORDIC: one reduction stage then one stage per iteration, one lane per angle.
// Depends on hstc_pkg.
`default_nettype none
module hstc_cordic
    import hstc_pkg::*;
#(
    parameter int DIM   = DIM_DEF,
    parameter int STEPS = STEPS_DEF
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic en,
    input  wire logic in_valid,
    input  wire q_t   in_radius,
    input  wire q_t   in_angle [DIM-1],
    output logic      out_valid,
    output q_t        out_radius,
    output q_t        out_sn [DIM-1],
    output q_t        out_cs [DIM-1]
);

    logic v_reg    [STEPS+1];
    q_t   r_reg    [STEPS+1];
    logic flip_reg [STEPS+1][DIM-1];
    cw_t  x_reg    [STEPS+1][DIM-1];
    cw_t  y_reg    [STEPS+1][DIM-1];
    cw_t  z_reg    [STEPS+1][DIM-1];

    // Valid bits travel with the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s <= STEPS; s++)
            begin
                v_reg[s] <= 1'b0;
            end
        end
        else if (en)
        begin
            v_reg[0] <= in_valid;
            for (int s = 1; s <= STEPS; s++)
            begin
                v_reg[s] <= v_reg[s-1];
            end
        end
    end

    // Angle reduction into the range of plus or minus pi/2.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg[0] <= in_radius;
            for (int l = 0; l < DIM - 1; l++)
            begin
                cw_t  a;
                cw_t  b;
                logic fl;
                a = cw_t'(in_angle[l]);
                if (a > Q28_PI)
                begin
                    a = a - Q28_TWO_PI;
                end
                else if (a < -Q28_PI)
                begin
                    a = a + Q28_TWO_PI;
                end
                b  = a;
                fl = 1'b0;
                if (a > Q28_HALF_PI)
                begin
                    b  = a - Q28_PI;
                    fl = 1'b1;
                end
                else if (a < -Q28_HALF_PI)
                begin
                    b  = a + Q28_PI;
                    fl = 1'b1;
                end
                flip_reg[0][l] <= fl;
                x_reg[0][l] <= Q30_GAIN;
                y_reg[0][l] <= '0;
                z_reg[0][l] <= b;
            end
        end
    end

    // One rotation per stage.
    for (genvar s = 0; s < STEPS; s++)
    begin : g_step
        localparam cw_t ATAN = atan_q28(s);
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                r_reg[s+1] <= r_reg[s];
                for (int l = 0; l < DIM - 1; l++)
                begin
                    flip_reg[s+1][l] <= flip_reg[s][l];
                    if (!z_reg[s][l][CW-1])
                    begin
                        x_reg[s+1][l] <= x_reg[s][l] - (y_reg[s][l] >>> s);
                        y_reg[s+1][l] <= y_reg[s][l] + (x_reg[s][l] >>> s);
                        z_reg[s+1][l] <= z_reg[s][l] - ATAN;
                    end
                    else
                    begin
                        x_reg[s+1][l] <= x_reg[s][l] + (y_reg[s][l] >>> s);
                        y_reg[s+1][l] <= y_reg[s][l] - (x_reg[s][l] >>> s);
                        z_reg[s+1][l] <= z_reg[s][l] + ATAN;
                    end
                end
            end
        end
    end

    // Undo the half-turn reduction.
    always_comb
    begin
        out_valid  = v_reg[STEPS];
        out_radius = r_reg[STEPS];
        for (int l = 0; l < DIM - 1; l++)
        begin
            out_sn[l] = q_t'(flip_reg[STEPS][l] ? -y_reg[STEPS][l] : y_reg[STEPS][l]);
            out_cs[l] = q_t'(flip_reg[STEPS][l] ? -x_reg[STEPS][l] : x_reg[STEPS][l]);
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/hstc_seq.sv =====
// Entry sequencer: holds one point and issues its entries, choosing the factors of each.
// Depends on hstc_pkg.
`default_nettype none
module hstc_seq
    import hstc_pkg::*;
#(
    parameter int DIM = DIM_DEF
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       en,
    input  wire logic [1:0] ord,
    input  wire logic       in_valid,
    input  wire q_t         in_radius,
    input  wire q_t         in_sn [DIM-1],
    input  wire q_t         in_cs [DIM-1],
    output logic            take,
    output logic            e_valid,
    output meta_t           e_meta,
    output q_t              e_radius,
    output q_t              e_fac [DIM-1]
);

    localparam logic [1:0] DMAX = 2'(DIM - 1);

    logic       h_valid_reg;
    q_t         h_r_reg;
    q_t         h_sn_reg [DIM-1];
    q_t         h_cs_reg [DIM-1];
    logic [1:0] i_reg, j_reg, k_reg;
    logic       ev_reg;
    meta_t      em_reg;
    q_t         er_reg;
    q_t         ef_reg [DIM-1];

    logic [1:0] jmax, kmax;
    logic       last_now;
    logic       emit;
    logic [1:0] d0;
    q_t         fac [DIM-1];

    always_comb
    begin
        jmax     = (ord >= ORD_JAC)  ? DMAX : 2'd0;
        kmax     = (ord >= ORD_HESS) ? DMAX : 2'd0;
        last_now = (i_reg == DMAX) && (j_reg == jmax) && (k_reg == kmax);
        emit     = en && h_valid_reg;
        take     = en && (!h_valid_reg || last_now);
        d0       = 2'((ord >= ORD_JAC && j_reg == 2'd0) ? 1 : 0)
                 + 2'((ord >= ORD_HESS && k_reg == 2'd0) ? 1 : 0);
        // Factor of angle m: sine, cosine, their negatives, one or zero, by differentiation count.
        for (int l = 0; l < DIM - 1; l++)
        begin
            logic [1:0] m;
            logic [1:0] dm;
            m  = 2'(l + 1);
            dm = 2'((ord >= ORD_JAC && j_reg == m) ? 1 : 0)
               + 2'((ord >= ORD_HESS && k_reg == m) ? 1 : 0);
            if (m <= i_reg)
            begin
                fac[l] = (dm == 2'd0) ? h_sn_reg[l] :
                         (dm == 2'd1) ? h_cs_reg[l] : -h_sn_reg[l];
            end
            else if ({1'b0, m} == {1'b0, i_reg} + 3'd1)
            begin
                fac[l] = (dm == 2'd0) ? h_cs_reg[l] :
                         (dm == 2'd1) ? -h_sn_reg[l] : -h_cs_reg[l];
            end
            else
            begin
                fac[l] = (dm == 2'd0) ? q_t'(32'sd1073741824) : '0;
            end
        end
    end

    // Point holding register and entry counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            h_valid_reg <= 1'b0;
            i_reg       <= '0;
            j_reg       <= '0;
            k_reg       <= '0;
            ev_reg      <= 1'b0;
        end
        else if (en)
        begin
            ev_reg <= h_valid_reg;
            if (take)
            begin
                h_valid_reg <= in_valid;
                i_reg       <= '0;
                j_reg       <= '0;
                k_reg       <= '0;
            end
            else if (emit)
            begin
                if (k_reg != kmax)
                begin
                    k_reg <= k_reg + 2'd1;
                end
                else
                begin
                    k_reg <= '0;
                    if (j_reg != jmax)
                    begin
                        j_reg <= j_reg + 2'd1;
                    end
                    else
                    begin
                        j_reg <= '0;
                        i_reg <= i_reg + 2'd1;
                    end
                end
            end
        end
    end

    // Payload of the held point and of the issued entry.
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            h_r_reg  <= in_radius;
            h_sn_reg <= in_sn;
            h_cs_reg <= in_cs;
        end
        if (en)
        begin
            em_reg.ci   <= i_reg;
            em_reg.fj   <= (ord >= ORD_JAC)  ? j_reg : 2'd0;
            em_reg.sk   <= (ord >= ORD_HESS) ? k_reg : 2'd0;
            em_reg.last <= last_now;
            em_reg.d0   <= d0;
            er_reg      <= h_r_reg;
            ef_reg      <= fac;
        end
    end

    assign e_valid  = ev_reg;
    assign e_meta   = em_reg;
    assign e_radius = er_reg;
    assign e_fac    = ef_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/hstc_mul.sv =====
// Product pipeline: chains the angle factors, scales by the radius (not for a first radial derivative) and saturates.
// Depends on hstc_pkg.
`default_nettype none
module hstc_mul
    import hstc_pkg::*;
#(
    parameter int DIM = DIM_DEF
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  en,
    input  wire logic  in_valid,
    input  wire meta_t in_meta,
    input  wire q_t    in_radius,
    input  wire q_t    in_fac [DIM-1],
    output logic       out_valid,
    output meta_t      out_meta,
    output q_t         out_value
);

    localparam int NS = DIM - 1;

    logic  v_st [NS];
    meta_t m_st [NS];
    q_t    r_st [NS];
    q_t    p_st [NS];
    q_t    f_st [NS][DIM-1];

    logic               va_reg;
    meta_t              ma_reg;
    q_t                 pa_reg;
    logic signed [63:0] prod_reg;
    logic               vo_reg;
    meta_t              mo_reg;
    q_t                 val_reg;

    assign v_st[0] = in_valid;
    assign m_st[0] = in_meta;
    assign r_st[0] = in_radius;
    assign p_st[0] = in_fac[0];
    assign f_st[0] = in_fac;

    // One factor multiplied in per stage.
    for (genvar t = 1; t < NS; t++)
    begin : g_prod
        logic  v_reg;
        meta_t m_reg;
        q_t    r_reg;
        q_t    p_reg;
        q_t    f_reg [DIM-1];
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg <= 1'b0;
            end
            else if (en)
            begin
                v_reg <= v_st[t-1];
            end
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                m_reg <= m_st[t-1];
                r_reg <= r_st[t-1];
                f_reg <= f_st[t-1];
                p_reg <= q_t'(rnd(64'(p_st[t-1]) * 64'(f_st[t-1][t]), 30));
            end
        end
        assign v_st[t] = v_reg;
        assign m_st[t] = m_reg;
        assign r_st[t] = r_reg;
        assign p_st[t] = p_reg;
        assign f_st[t] = f_reg;
    end

    // Radius product, then rounding and saturation into the output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else if (en)
        begin
            va_reg <= v_st[NS-1];
            vo_reg <= va_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            logic signed [63:0] v;
            ma_reg   <= m_st[NS-1];
            pa_reg   <= p_st[NS-1];
            prod_reg <= 64'(r_st[NS-1]) * 64'(p_st[NS-1]);
            mo_reg   <= ma_reg;
            case (ma_reg.d0)
                2'd0:    v = rnd(prod_reg, 30);
                2'd1:    v = rnd(64'(pa_reg), 14);
                default: v = '0;
            endcase
            if (v > 64'sd2147483647)
            begin
                val_reg <= q_t'(32'sh7fffffff);
            end
            else if (v < -64'sd2147483648)
            begin
                val_reg <= q_t'(32'sh80000000);
            end
            else
            begin
                val_reg <= q_t'(v[31:0]);
            end
        end
    end

    assign out_valid = vo_reg;
    assign out_meta  = mo_reg;
    assign out_value = val_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/hyperspherical_to_cartesian_derivs.sv =====
// Maps a point in hyperspherical coordinates to Cartesian components, their Jacobian or their
// Hessian, as chosen by the order register, and sends the entries one per cycle on the master side
// while tready does not hold them back, ordered by component, then first and second direction,
// with tlast on the final entry of a point. A point yields DIM^(order+1) entries and the next
// point is taken as the last entry of the current one is issued. The whole pipeline halts while
// a result waits on tready.
`default_nettype none
`include "assert_macros.svh"
module hyperspherical_to_cartesian_derivs
    import hstc_pkg::*;
#(
    parameter int DIM          = DIM_DEF,
    parameter int CORDIC_STEPS = STEPS_DEF
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         cfg_we,
    input  wire logic [1:0]   cfg_wdata,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [127:0] s_tdata,  // radius, angle_1, angle_2, unused upper word
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [39:0]       m_tdata,  // component_index, first_direction,
                                        // second_direction, component_value, zero pad
    output logic              m_tlast
);

    logic [1:0] ord_reg;
    logic [1:0] ord;
    logic       en;
    logic       take;
    q_t         angles [DIM-1];
    logic       c_valid;
    q_t         c_radius;
    q_t         c_sn [DIM-1];
    q_t         c_cs [DIM-1];
    logic       e_valid;
    meta_t      e_meta;
    q_t         e_radius;
    q_t         e_fac [DIM-1];
    meta_t      o_meta;
    q_t         o_value;

    // Order register; the unused code three behaves as the Hessian.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ord_reg <= ORD_VAL;
        end
        else if (cfg_we)
        begin
            ord_reg <= cfg_wdata;
        end
    end

    assign ord      = (ord_reg > ORD_HESS) ? ORD_HESS : ord_reg;
    assign en       = !m_tvalid || m_tready;
    assign s_tready = take;

    always_comb
    begin
        for (int l = 0; l < DIM - 1; l++)
        begin
            angles[l] = q_t'(s_tdata[32*(l+1) +: 32]);
        end
    end

    hstc_cordic #(.DIM(DIM), .STEPS(CORDIC_STEPS)) u_cordic (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (take),
        .in_valid   (s_tvalid),
        .in_radius  (q_t'(s_tdata[31:0])),
        .in_angle   (angles),
        .out_valid  (c_valid),
        .out_radius (c_radius),
        .out_sn     (c_sn),
        .out_cs     (c_cs)
    );

    hstc_seq #(.DIM(DIM)) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .ord       (ord),
        .in_valid  (c_valid),
        .in_radius (c_radius),
        .in_sn     (c_sn),
        .in_cs     (c_cs),
        .take      (take),
        .e_valid   (e_valid),
        .e_meta    (e_meta),
        .e_radius  (e_radius),
        .e_fac     (e_fac)
    );

    hstc_mul #(.DIM(DIM)) u_mul (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (e_valid),
        .in_meta   (e_meta),
        .in_radius (e_radius),
        .in_fac    (e_fac),
        .out_valid (m_tvalid),
        .out_meta  (o_meta),
        .out_value (o_value)
    );

    assign m_tdata = {2'b00, o_value, o_meta.sk, o_meta.fj, o_meta.ci};
    assign m_tlast = o_meta.last;

    // Checks on the entry sequencing.
    `ASSERT_IMPL(a_ready_adv, clk, rst_n, s_tready, en)
    `ASSERT_IMPL(a_idx_range, clk, rst_n, m_tvalid, m_tdata[1:0] <= 2'(DIM - 1))
    `ASSERT_IMPL(a_last_idx, clk, rst_n, m_tvalid && m_tlast, m_tdata[1:0] == 2'(DIM - 1))
    `ASSERT_IMPL(a_ord0_dirs, clk, rst_n, m_tvalid && ord == ORD_VAL, m_tdata[5:2] == 4'd0)

endmodule
`default_nettype wire
